// ----- design/ahdu_pkg.sv -----
// shared types and constants for the ascii hex/decimal string to integer parser
// no dependencies
package ahdu_pkg;

  // widest value the output words can carry
  localparam int unsigned OUT_BITS = 256;
  localparam int unsigned WORD_BITS = 64;

  // character codes
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_F   = 8'h66;
  localparam logic [7:0] CHAR_UP_A    = 8'h41;
  localparam logic [7:0] CHAR_UP_F    = 8'h46;
  localparam logic [7:0] CHAR_LOW_X   = 8'h78;
  localparam logic [7:0] CHAR_UP_X    = 8'h58;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  // saturating character position
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_DIGIT = 2'd1,
    OP_BAD   = 2'd2
  } op_kind_e;

  // one classified character, handed from front to back
  typedef struct packed {
    op_kind_e   kind;
    logic       radix16;
    logic [3:0] digit;
    logic       hex_seen;
    logic       last;
  } op_t;

endpackage

// ----- design/ahdu_in_if.sv -----
// input channel: one character item per handshake
// no dependencies
interface ahdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       last_char;

  modport source (output valid, output char_code, output char_present, output last_char,
                  input ready);
  modport sink (input valid, input char_code, input char_present, input last_char,
                output ready);
endinterface

// ----- design/ahdu_out_if.sv -----
// output channel: one parsed value item per handshake
// no dependencies
interface ahdu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_word0;
  logic [63:0] value_word1;
  logic [63:0] value_word2;
  logic [63:0] value_word3;
  logic        parse_status;
  logic        was_hex;

  modport source (output valid, output value_word0, output value_word1,
                  output value_word2, output value_word3, output parse_status,
                  output was_hex, input ready);
  modport sink (input valid, input value_word0, input value_word1, input value_word2,
                input value_word3, input parse_status, input was_hex, output ready);
endinterface

// ----- design/ahdu_front.sv -----
// front end: accepts characters, tracks prefix state and classifies each one
// depends on ahdu_pkg and ahdu_in_if
module ahdu_front import ahdu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ahdu_in_if.sink   in_ch_i,
  input  logic      full_i,
  output logic      push_o,
  output op_t       op_o
);

  logic [1:0] pos_q, pos_d;
  logic       hex_q, hex_d;
  logic       first_zero_q, first_zero_d;
  logic [7:0] c;
  logic       is_dec, is_low, is_up, is_x;

  assign in_ch_i.ready = !full_i;
  assign push_o        = in_ch_i.valid && !full_i;
  assign c             = in_ch_i.char_code;

  assign is_dec = (c >= CHAR_0) && (c <= CHAR_9);
  assign is_low = (c >= CHAR_LOW_A) && (c <= CHAR_LOW_F);
  assign is_up  = (c >= CHAR_UP_A) && (c <= CHAR_UP_F);
  assign is_x   = (c == CHAR_LOW_X) || (c == CHAR_UP_X);

  always_comb begin
    op_o.kind    = OP_NONE;
    op_o.radix16 = hex_q;
    op_o.digit   = '0;
    op_o.last    = in_ch_i.last_char;
    hex_d        = hex_q;
    if (in_ch_i.char_present) begin
      if (hex_q) begin
        if (is_dec) begin
          op_o.kind  = OP_DIGIT;
          op_o.digit = 4'(c - CHAR_0);
        end else if (is_low) begin
          op_o.kind  = OP_DIGIT;
          op_o.digit = 4'(c - CHAR_LOW_A) + HEX_LETTER_BASE;
        end else if (is_up) begin
          op_o.kind  = OP_DIGIT;
          op_o.digit = 4'(c - CHAR_UP_A) + HEX_LETTER_BASE;
        end else begin
          op_o.kind = OP_BAD;
        end
      end else if ((pos_q == POS_SECOND) && first_zero_q && is_x) begin
        // "0x" prefix: accumulator is still zero, just switch radix
        hex_d = 1'b1;
      end else if (is_dec) begin
        op_o.kind  = OP_DIGIT;
        op_o.digit = 4'(c - CHAR_0);
      end else begin
        op_o.kind = OP_BAD;
      end
    end
    op_o.hex_seen = hex_d;
  end

  always_comb begin
    pos_d        = pos_q;
    first_zero_d = first_zero_q;
    if (in_ch_i.char_present) begin
      if (pos_q == POS_FIRST) begin
        first_zero_d = (c == CHAR_0);
      end
      if (pos_q != POS_LATER) begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_FIRST;
      hex_q        <= 1'b0;
      first_zero_q <= 1'b0;
    end else if (push_o) begin
      if (in_ch_i.last_char) begin
        pos_q        <= POS_FIRST;
        hex_q        <= 1'b0;
        first_zero_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        hex_q        <= hex_d;
        first_zero_q <= first_zero_d;
      end
    end
  end

endmodule

// ----- design/ahdu_fifo.sv -----
// two-entry queue of classified characters between front and back
// depends on ahdu_pkg
module ahdu_fifo import ahdu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/ahdu_back.sv -----
// back end: shift-and-add accumulator and registered result stage
// depends on ahdu_pkg and ahdu_out_if
module ahdu_back import ahdu_pkg::*; #(
  parameter int unsigned VALUE_BITS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  op_t       op_i,
  output logic      pop_o,
  ahdu_out_if.source out_ch_o
);

  logic [VALUE_BITS-1:0] acc_q;
  logic [VALUE_BITS-1:0] acc_d;
  logic [VALUE_BITS-1:0] acc_scaled;
  logic                  bad_q;
  logic                  bad_d;
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   value_q;
  logic                  status_q;
  logic                  hex_q;
  logic                  out_free;

  // times 16 is a shift, times 10 is x8 + x2
  assign acc_scaled = op_i.radix16 ? (acc_q << 4) : ((acc_q << 3) + (acc_q << 1));

  always_comb begin
    acc_d = acc_q;
    bad_d = bad_q;
    case (op_i.kind)
      OP_DIGIT: acc_d = acc_scaled + VALUE_BITS'(op_i.digit);
      OP_BAD:   bad_d = 1'b1;
      default:  acc_d = acc_q;
    endcase
  end

  assign out_free = !out_valid_q || out_ch_o.ready;
  assign pop_o    = valid_i && (!op_i.last || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (op_i.last) begin
          acc_q <= '0;
          bad_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          bad_q <= bad_d;
        end
      end
      if (pop_o && op_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.last) begin
      value_q  <= bad_d ? '0 : OUT_BITS'(acc_d);
      status_q <= bad_d;
      hex_q    <= op_i.hex_seen;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.value_word0  = value_q[WORD_BITS-1:0];
  assign out_ch_o.value_word1  = value_q[2*WORD_BITS-1:WORD_BITS];
  assign out_ch_o.value_word2  = value_q[3*WORD_BITS-1:2*WORD_BITS];
  assign out_ch_o.value_word3  = value_q[4*WORD_BITS-1:3*WORD_BITS];
  assign out_ch_o.parse_status = status_q;
  assign out_ch_o.was_hex      = hex_q;

`ifndef NO_ASSERTIONS
  // an error result never carries a value
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> value_q == '0)
    else $error("error result with nonzero value");

  // end of string leaves a clean accumulator
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && op_i.last |=> acc_q == '0 && !bad_q)
    else $error("state not cleared after last item");

  // a stalled result is never overwritten by the next string end
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch_o.ready && valid_i && op_i.last |-> !pop_o)
    else $error("result overwritten while stalled");

  // pops only happen with a queued item
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> valid_i)
    else $error("pop from empty queue");
`endif

endmodule

// ----- design/ascii_hex_or_decimal_to_u256_core.sv -----
// top level of the ascii hex/decimal string to integer parser
// depends on ahdu_pkg, ahdu_in_if, ahdu_out_if, ahdu_front, ahdu_fifo, ahdu_back
//
// Streams an ASCII number one character per item and returns one result item when an item
// marked last_char is taken: the value as four 64-bit words, a parse status and a hex flag.
// A leading "0x" or "0X" switches to hex digits; otherwise only decimal digits are valid,
// and any invalid character forces parse_status to 1 with all value words zero. The value
// wraps modulo 2^VALUE_BITS (bits above it read zero). Throughput is one character per
// clock, sustained, also while a finished result waits on the output, until an item
// marked last_char reaches the back stage and must wait for that result to be taken.
// The front stage classifies each character in the cycle it is accepted and pushes it
// into a two-entry queue; the back stage performs one times-10 or times-16 shift-and-add
// on the wide accumulator per popped character, which is the longest path in the block.
// A last character passes through its queue entry and then the output register, where its
// result sits until taken. Input stalls only when that register and the queue are both full.
module ascii_hex_or_decimal_to_u256_core import ahdu_pkg::*; #(
  parameter int unsigned VALUE_BITS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahdu_in_if.sink    in_ch_i,
  ahdu_out_if.source out_ch_o
);

  // front to queue
  logic push;
  op_t  push_op;
  logic full;

  // queue to back
  logic pop;
  logic queued;
  op_t  head_op;

  ahdu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .full_i  (full),
    .push_o  (push),
    .op_o    (push_op)
  );

  ahdu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queued),
    .op_o    (head_op)
  );

  ahdu_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (queued),
    .op_i     (head_op),
    .pop_o    (pop),
    .out_ch_o (out_ch_o)
  );

endmodule

// ----- tb/sv/ascii_hex_or_decimal_to_u256_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the ascii hex/decimal string to 256-bit integer parser
// depends on ahdu_pkg, ahdu_in_if, ahdu_out_if and ascii_hex_or_decimal_to_u256_core
module ascii_hex_or_decimal_to_u256_core_tb;
  import ahdu_pkg::*;

  localparam int unsigned VALUE_BITS = 256;
  // bits at or above VALUE_BITS always read zero
  localparam logic [OUT_BITS-1:0] VALUE_MASK = {OUT_BITS{1'b1}} >> (OUT_BITS - VALUE_BITS);

  // one parsed value as the output channel carries it
  typedef struct packed {
    logic [WORD_BITS-1:0] word3;
    logic [WORD_BITS-1:0] word2;
    logic [WORD_BITS-1:0] word1;
    logic [WORD_BITS-1:0] word0;
    logic                 parse_status;
    logic                 was_hex;
  } parsed_value_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ahdu_in_if  in_ch ();
  ahdu_out_if out_ch ();

  ascii_hex_or_decimal_to_u256_core #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // knobs for the current phase: sender gaps, receiver stalls, empty filler items
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned empty_item_pct;
  int unsigned chars_sent;
  int unsigned mismatch_count;

  // parsed values still owed by the block, oldest first
  parsed_value_t expected_values[$];

  // shadow of the parser state
  logic [OUT_BITS-1:0] acc_shadow;
  logic [1:0]          char_pos;
  logic                hex_mode;
  logic                bad_seen;

  // fold one accepted character into the shadow accumulator
  task automatic parse_char(input logic [7:0] c);
    logic [3:0] nibble;
    logic       nibble_ok;
    nibble    = '0;
    nibble_ok = 1'b1;
    if (hex_mode) begin
      if (c >= CHAR_0 && c <= CHAR_9) begin
        nibble = 4'(c - CHAR_0);
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
        nibble = 4'(c - CHAR_LOW_A) + HEX_LETTER_BASE;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
        nibble = 4'(c - CHAR_UP_A) + HEX_LETTER_BASE;
      end else begin
        nibble_ok = 1'b0;
      end
      if (nibble_ok) begin
        acc_shadow = (acc_shadow * 16 + nibble) & VALUE_MASK;
      end else begin
        bad_seen = 1'b1;
      end
    end else if (char_pos == POS_SECOND && (c == CHAR_LOW_X || c == CHAR_UP_X) &&
                 !bad_seen && acc_shadow == '0) begin
      // only a leading '0' leaves a clean zero accumulator at the second character
      hex_mode = 1'b1;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      acc_shadow = (acc_shadow * 10 + (c - CHAR_0)) & VALUE_MASK;
    end else begin
      bad_seen = 1'b1;
    end
    if (char_pos != POS_LATER) char_pos = char_pos + 2'd1;
  endtask

  // end of string: queue the value the block owes, then clear the shadow state
  task automatic close_string();
    parsed_value_t v;
    v.word0        = bad_seen ? '0 : acc_shadow[63:0];
    v.word1        = bad_seen ? '0 : acc_shadow[127:64];
    v.word2        = bad_seen ? '0 : acc_shadow[191:128];
    v.word3        = bad_seen ? '0 : acc_shadow[255:192];
    v.parse_status = bad_seen;
    v.was_hex      = hex_mode;
    expected_values.insert(expected_values.size(), v);
    acc_shadow = '0;
    char_pos   = POS_FIRST;
    hex_mode   = 1'b0;
    bad_seen   = 1'b0;
  endtask

  // one handshake on the input channel; called at a falling edge, returns at one
  task automatic push_item(input logic [7:0] c, input logic present, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.char_code    = c;
    in_ch.char_present = present;
    in_ch.last_char    = last;
    do @(posedge clk); while (!in_ch.ready);
    if (present) begin
      parse_char(c);
      chars_sent++;
    end
    if (last) close_string();
    @(negedge clk);
  endtask

  // a character item, sometimes preceded by an empty filler item that must change nothing
  task automatic send_char(input logic [7:0] c, input logic present, input logic last);
    if (present && $urandom_range(99) < empty_item_pct) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b0);
    end
    push_item(c, present, last);
  endtask

  // a whole string; the end is either on the final character or on an empty end item
  task automatic send_bytes(input byte unsigned txt[$], input bit empty_end);
    foreach (txt[i]) begin
      send_char(txt[i], 1'b1, (i == txt.size() - 1) && !empty_end);
    end
    if (empty_end || txt.size() == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_literal(input string s, input bit empty_end);
    byte unsigned txt[$];
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
    send_bytes(txt, empty_end);
  endtask

  function automatic byte unsigned hex_char(input int unsigned v, input bit upper);
    if (v < 10) return 8'(CHAR_0 + v);
    return upper ? 8'(CHAR_UP_A + v - 10) : 8'(CHAR_LOW_A + v - 10);
  endfunction

  // extremes and every special case, one short string each
  task automatic test_directed_strings();
    send_literal("", 1'b0);                // empty string
    send_literal("9", 1'b0);
    // bare prefix, with an empty item between '0' and 'x' that must not move the position
    send_char(CHAR_0, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CHAR_LOW_X, 1'b1, 1'b1);
    send_literal("0XAf09", 1'b0);          // upper prefix, both letter cases
    send_literal("1x", 1'b0);              // x after a nonzero digit is invalid
    send_literal("00x", 1'b0);             // x as third character is invalid
    send_literal("x", 1'b0);               // x as first character is invalid
    // lowest and highest codes, string closed by an empty end item
    send_char(8'h00, 1'b1, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h5A, 1'b0, 1'b1);
    send_literal("0xg", 1'b0);             // non-hex letter in hex mode
  endtask

  // decimal strings, mostly short, some long enough to wrap past 2^256
  task automatic test_decimal_strings(input int unsigned budget);
    int unsigned  stop;
    int unsigned  len;
    bit           all_nines;
    byte unsigned txt[$];
    stop = chars_sent + budget;
    while (chars_sent < stop) begin
      txt.delete();
      len = ($urandom_range(99) < 85) ? $urandom_range(20, 1) : $urandom_range(90, 70);
      all_nines = ($urandom_range(9) == 0);
      repeat (len) begin
        txt.insert(txt.size(), all_nines ? CHAR_9 : 8'(CHAR_0 + $urandom_range(9)));
      end
      send_bytes(txt, $urandom_range(3) == 0);
    end
  endtask

  // prefixed hex strings, some with more than 64 digits so the top digits fall off
  task automatic test_hex_strings(input int unsigned budget);
    int unsigned  stop;
    int unsigned  len;
    bit           all_f;
    byte unsigned txt[$];
    stop = chars_sent + budget;
    while (chars_sent < stop) begin
      txt.delete();
      txt.insert(txt.size(), CHAR_0);
      txt.insert(txt.size(), $urandom_range(1) ? CHAR_UP_X : CHAR_LOW_X);
      len = ($urandom_range(99) < 85) ? $urandom_range(16, 0) : $urandom_range(70, 60);
      all_f = ($urandom_range(9) == 0);
      repeat (len) begin
        txt.insert(txt.size(),
                   hex_char(all_f ? 15 : $urandom_range(15), $urandom_range(1) == 1));
      end
      send_bytes(txt, $urandom_range(3) == 0);
    end
  endtask

  // well-formed strings with one character spoiled, plus pure byte noise
  task automatic test_malformed_strings(input int unsigned budget);
    int unsigned  stop;
    int unsigned  len;
    bit           as_hex;
    byte unsigned txt[$];
    stop = chars_sent + budget;
    while (chars_sent < stop) begin
      txt.delete();
      if ($urandom_range(99) < 70) begin
        as_hex = ($urandom_range(1) == 1);
        len = $urandom_range(12, 1);
        if (as_hex) begin
          txt.insert(txt.size(), CHAR_0);
          txt.insert(txt.size(), $urandom_range(1) ? CHAR_UP_X : CHAR_LOW_X);
        end
        repeat (len) begin
          txt.insert(txt.size(),
                     as_hex ? hex_char($urandom_range(15), $urandom_range(1) == 1)
                            : 8'(CHAR_0 + $urandom_range(9)));
        end
        // stray x, or any byte at all, at a random position (may hit the prefix)
        txt[$urandom_range(txt.size() - 1)] =
          ($urandom_range(3) == 0) ? ($urandom_range(1) ? CHAR_UP_X : CHAR_LOW_X)
                                   : 8'($urandom_range(255));
      end else begin
        len = $urandom_range(8, 1);
        repeat (len) txt.insert(txt.size(), 8'($urandom_range(255)));
      end
      send_bytes(txt, $urandom_range(3) == 0);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: stall decided once per cycle at the falling edge
  always @(negedge clk) begin
    out_ch.ready = rst_n && ($urandom_range(99) >= sink_idle_pct);
  end

  // every taken result is held against the oldest value still owed
  always @(posedge clk) begin
    parsed_value_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h %h %h %h %b %b",
                 $time, out_ch.value_word3, out_ch.value_word2, out_ch.value_word1,
                 out_ch.value_word0, out_ch.parse_status, out_ch.was_hex);
        mismatch_count++;
      end else begin
        want = expected_values.pop_front();
        compare_field("value_word0", want.word0, out_ch.value_word0);
        compare_field("value_word1", want.word1, out_ch.value_word1);
        compare_field("value_word2", want.word2, out_ch.value_word2);
        compare_field("value_word3", want.word3, out_ch.value_word3);
        compare_field("parse_status", 64'(want.parse_status), 64'(out_ch.parse_status));
        compare_field("was_hex", 64'(want.was_hex), 64'(out_ch.was_hex));
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.char_present = 1'b0;
    in_ch.last_char    = 1'b0;
    out_ch.ready       = 1'b0;
    src_idle_pct       = 21;
    sink_idle_pct      = 83;
    empty_item_pct     = 0;
    chars_sent         = 0;
    mismatch_count     = 0;
    acc_shadow         = '0;
    char_pos           = POS_FIRST;
    hex_mode           = 1'b0;
    bad_seen           = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_strings();

    // random part in three idle phases: slow receiver, slow sender, full speed
    empty_item_pct = 4;
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 83 : 0;
      sink_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 21 : 0;
      test_decimal_strings(50);
      test_hex_strings(50);
      test_malformed_strings(50);
    end
    in_ch.valid = 1'b0;

    // drain, then keep watching for anything unexpected to show up
    while (expected_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
